### rtl/npf_pkg.sv
// ----------------------------------------------------------------------------
// npf_pkg
// shared widths and types for the next prime finder
// ----------------------------------------------------------------------------
package npf_pkg;

    localparam int IN_W    = 32;
    localparam int CAND_W  = 31;
    localparam int DIV_W   = 16;
    localparam int SQ_W    = 32;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0]  DIV_STEPS   = 5'd31;
    localparam logic [CAND_W-1:0] SMALL_PRIME = 31'd2;
    localparam logic [DIV_W-1:0]  FIRST_DIV   = 16'd3;
    localparam logic [SQ_W-1:0]   FIRST_SQ    = 32'd9;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

### rtl/next_prime_finder_core.sv
// ----------------------------------------------------------------------------
// next_prime_finder_core
// smallest prime not less than a signed 32-bit start value
// ----------------------------------------------------------------------------
// usage:
//   the input channel (in_valid, in_stall, start_value) takes one word at a
//   time; in_stall stays high from acceptance until the result is loaded
//   into the output register. the output channel (out_valid, out_stall,
//   next_prime) holds that word until taken, and a new input word may be
//   accepted while it waits.
//   start values below 2, negatives included, give 2.
//   each candidate is tried against odd divisors 3, 5, 7, ... up to its
//   square root; every divisor takes one pass of the bit-serial remainder
//   unit (31 shift steps plus issue and check), so the time from acceptance
//   to out_valid grows with the number of candidates and divisors tried,
//   and is longest for a large prime.
//   when the receiver stalls with a result already held, the search ends
//   and waits for the output register to free up.
//   reset clears all control state; the block is idle and ready afterwards.
// ----------------------------------------------------------------------------
module next_prime_finder_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [npf_pkg::IN_W-1:0]    start_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [npf_pkg::CAND_W-1:0]  next_prime
);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        BOUND,
        DIVIDE,
        FINISH
    } state_t;

    state_t                     state_reg;
    logic [npf_pkg::CAND_W-1:0] cand_reg;
    logic [npf_pkg::DIV_W-1:0]  divisor_reg;
    logic [npf_pkg::SQ_W-1:0]   sq_reg;
    logic                       out_valid_reg;
    logic [npf_pkg::CAND_W-1:0] next_prime_reg;
    logic                       below_two;
    logic                       past_root;
    logic                       div_start;
    logic                       in_accept;
    logic                       out_free;
    logic                       out_load;
    npf_pkg::rem_status_t       rem_status;

    assign in_accept = in_valid && (state_reg == IDLE);
    assign in_stall  = (state_reg != IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == FINISH) && out_free;
    assign below_two = start_value[npf_pkg::IN_W-1]
                       || (start_value[npf_pkg::IN_W-2:1] == '0);
    assign past_root = (sq_reg > {1'b0, cand_reg});
    assign div_start = (state_reg == BOUND) && !past_root;

    npf_rem_unit u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (divisor_reg),
        .status   (rem_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cand_reg       <= '0;
            divisor_reg    <= '0;
            sq_reg         <= '0;
            out_valid_reg  <= 1'b0;
            next_prime_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_accept)
                    begin
                        cand_reg  <= below_two ? npf_pkg::SMALL_PRIME
                                               : start_value[npf_pkg::CAND_W-1:0];
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    if (cand_reg == npf_pkg::SMALL_PRIME)
                    begin
                        state_reg <= FINISH;
                    end
                    else if (!cand_reg[0])
                    begin
                        cand_reg <= cand_reg + 1'b1;
                    end
                    else
                    begin
                        divisor_reg <= npf_pkg::FIRST_DIV;
                        sq_reg      <= npf_pkg::FIRST_SQ;
                        state_reg   <= BOUND;
                    end
                end
                BOUND:
                begin
                    state_reg <= past_root ? FINISH : DIVIDE;
                end
                DIVIDE:
                begin
                    if (rem_status.done)
                    begin
                        if (rem_status.zero)
                        begin
                            cand_reg  <= cand_reg + 1'b1;
                            state_reg <= CHECK;
                        end
                        else
                        begin
                            // (d+2)^2 = d^2 + 4d + 4
                            sq_reg      <= sq_reg + {14'd0, divisor_reg, 2'b00} + 32'd4;
                            divisor_reg <= divisor_reg + 16'd2;
                            state_reg   <= BOUND;
                        end
                    end
                end
                FINISH:
                begin
                    if (out_free)
                    begin
                        next_prime_reg <= cand_reg;
                        state_reg      <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_prime = next_prime_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted but block not busy");

    a_result_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_prime >= npf_pkg::SMALL_PRIME)
        else $error("result below smallest prime");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        rem_status.done |-> state_reg == DIVIDE)
        else $error("remainder finished outside divide state");

    a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BOUND |-> divisor_reg[0])
        else $error("even trial divisor");

endmodule

### rtl/npf_rem_unit.sv
// ----------------------------------------------------------------------------
// npf_rem_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module npf_rem_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [npf_pkg::CAND_W-1:0]   dividend,
    input  logic [npf_pkg::DIV_W-1:0]    divisor,
    output npf_pkg::rem_status_t         status
);

    logic [npf_pkg::CAND_W-1:0] shift_reg;
    logic [npf_pkg::DIV_W-1:0]  divisor_reg;
    logic [npf_pkg::DIV_W-1:0]  rem_reg;
    logic [npf_pkg::DIV_W-1:0]  rem_next;
    logic [npf_pkg::CNT_W-1:0]  count_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       zero_reg;
    logic [npf_pkg::DIV_W:0]    trial;
    logic [npf_pkg::DIV_W+1:0]  diff;

    assign trial    = {rem_reg, shift_reg[npf_pkg::CAND_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, divisor_reg};
    assign rem_next = diff[npf_pkg::DIV_W+1] ? trial[npf_pkg::DIV_W-1:0]
                                             : diff[npf_pkg::DIV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '0;
            divisor_reg <= '0;
            rem_reg     <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            zero_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                shift_reg   <= dividend;
                divisor_reg <= divisor;
                rem_reg     <= '0;
                count_reg   <= npf_pkg::DIV_STEPS;
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                shift_reg <= {shift_reg[npf_pkg::CAND_W-2:0], 1'b0};
                rem_reg   <= rem_next;
                count_reg <= count_reg - 1'b1;
                if (count_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    zero_reg <= (rem_next == '0);
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.zero = zero_reg;

endmodule
